@@ rtl/clause_watch_evaluator_unit_assert.svh @@
// Assertion macros for the clause watch evaluator.
// Used by clause_watch_evaluator_unit; expects clk and rst_n in scope.
`ifndef CLAUSE_WATCH_EVALUATOR_UNIT_ASSERT_SVH
`define CLAUSE_WATCH_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CWE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clause watch evaluator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clause watch evaluator: next-cycle check failed");

`endif

@@ rtl/cwe_pkg.sv @@
// Shared types and constants for the clause watch evaluator.
// No dependencies; imported by cwe_eval and clause_watch_evaluator_unit.
`timescale 1ns / 1ps

package cwe_pkg;

    localparam int MAX_LITS    = 8;
    localparam int LANE_CNT    = 8;
    // Lanes that can take part: the value word holds eight lanes.
    localparam int EFF_LANES   = (MAX_LITS < LANE_CNT) ? MAX_LITS : LANE_CNT;

    localparam int LANE_W      = 3;
    localparam int LEN_W       = 4;
    localparam int LIT_W       = 16;
    localparam int VAL_W       = 2;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [VAL_W-1:0] VAL_FALSE = 2'd0;
    localparam logic [VAL_W-1:0] VAL_TRUE  = 2'd1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_INIT   = 1'b1;

    // Register index, taken from paddr word bits.
    localparam logic [APB_ADDR_W-3:0] REG_USE_WATCHED = '0;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_MOVED      = 3'd1,
        EV_UNIT       = 3'd2,
        EV_CONFLICT   = 3'd3,
        EV_OTHER_TRUE = 3'd4
    } watch_event_t;

    typedef struct packed {
        logic                          kind;
        logic [LANE_CNT*VAL_W-1:0]     literal_values;
        logic [LEN_W-1:0]              clause_length;
        logic [LANE_W-1:0]             watch_a;
        logic [LANE_W-1:0]             watch_b;
        logic signed [LIT_W-1:0]       lit_a;
        logic signed [LIT_W-1:0]       lit_b;
        logic signed [LIT_W-1:0]       falsed_literal;
    } in_word_t;

    typedef struct packed {
        logic                          satisfied;
        logic                          all_false;
        logic                          is_unit;
        logic                          any_unassigned;
        logic [LANE_W-1:0]             unit_position;
        logic [LANE_W-1:0]             new_watch_a;
        logic [LANE_W-1:0]             new_watch_b;
        watch_event_t                  watch_event;
        logic signed [LIT_W-1:0]       unit_literal;
    } out_word_t;

endpackage

@@ rtl/cwe_eval.sv @@
// Combinational clause evaluation and watch update for one word.
// Depends on cwe_pkg; instantiated by clause_watch_evaluator_unit.
`timescale 1ns / 1ps

module cwe_eval (
    input  cwe_pkg::in_word_t  cmd,
    input  logic               use_watched,
    output cwe_pkg::out_word_t result
);
    import cwe_pkg::*;

    logic [VAL_W-1:0]    lane_val [LANE_CNT];
    logic [LANE_CNT-1:0] in_len;
    logic [LANE_CNT-1:0] true_mask;
    logic [LANE_CNT-1:0] unk_mask;
    logic [LANE_CNT-1:0] cand_mask;
    logic [LEN_W-1:0]    len_eff;
    logic [LANE_W-1:0]   upos;
    logic [LANE_W-1:0]   cand_pos;
    logic                hit_a;
    logic                hit_any;
    logic [LANE_W-1:0]   other_lane;
    logic [VAL_W-1:0]    other_val;
    logic signed [LIT_W-1:0] other_lit;

    assign len_eff = (cmd.clause_length > LEN_W'(EFF_LANES)) ? LEN_W'(EFF_LANES)
                                                             : cmd.clause_length;

    always_comb
    begin
        for (int k = 0; k < LANE_CNT; k++)
        begin
            lane_val[k]  = cmd.literal_values[k*VAL_W +: VAL_W];
            in_len[k]    = LEN_W'(k) < len_eff;
            true_mask[k] = in_len[k] && (lane_val[k] == VAL_TRUE);
            unk_mask[k]  = in_len[k] && (lane_val[k] != VAL_TRUE)
                                     && (lane_val[k] != VAL_FALSE);
            cand_mask[k] = in_len[k] && (lane_val[k] != VAL_FALSE)
                                     && (LANE_W'(k) != cmd.watch_a)
                                     && (LANE_W'(k) != cmd.watch_b);
        end
    end

    // Lowest set lane wins: scan from the top down.
    always_comb
    begin
        upos     = '0;
        cand_pos = '0;
        for (int k = LANE_CNT - 1; k >= 0; k--)
        begin
            if (unk_mask[k])
                upos = LANE_W'(k);
            if (cand_mask[k])
                cand_pos = LANE_W'(k);
        end
    end

    assign hit_a      = (cmd.lit_a == cmd.falsed_literal);
    assign hit_any    = hit_a || (cmd.lit_b == cmd.falsed_literal);
    assign other_lane = hit_a ? cmd.watch_b : cmd.watch_a;
    assign other_lit  = hit_a ? cmd.lit_b : cmd.lit_a;
    assign other_val  = lane_val[other_lane];

    always_comb
    begin
        result.satisfied      = |true_mask;
        result.all_false      = ~|true_mask && ~|unk_mask;
        result.is_unit        = ~|true_mask && $onehot(unk_mask);
        result.any_unassigned = |unk_mask;
        result.unit_position  = upos;
        result.new_watch_a    = cmd.watch_a;
        result.new_watch_b    = cmd.watch_b;
        result.watch_event    = EV_NONE;
        result.unit_literal   = '0;

        if (use_watched && (len_eff >= LEN_W'(2)))
        begin
            if (cmd.kind == KIND_INIT)
            begin
                // Swap so a false lane 0 is not the first watch.
                if (lane_val[0] == VAL_FALSE)
                begin
                    result.new_watch_a = LANE_W'(1);
                    result.new_watch_b = LANE_W'(0);
                end
                else
                begin
                    result.new_watch_a = LANE_W'(0);
                    result.new_watch_b = LANE_W'(1);
                end
            end
            else if (hit_any)
            begin
                if (|cand_mask)
                begin
                    result.watch_event = EV_MOVED;
                    if (hit_a)
                        result.new_watch_a = cand_pos;
                    else
                        result.new_watch_b = cand_pos;
                end
                else if (other_val == VAL_FALSE)
                    result.watch_event = EV_CONFLICT;
                else if (other_val == VAL_TRUE)
                    result.watch_event = EV_OTHER_TRUE;
                else
                begin
                    result.watch_event  = EV_UNIT;
                    result.unit_literal = other_lit;
                end
            end
        end
    end

endmodule

@@ rtl/clause_watch_evaluator_unit.sv @@
// Top level of the clause watch evaluator: command port, APB register, pipeline.
// Depends on cwe_pkg, cwe_eval and clause_watch_evaluator_unit_assert.svh.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive cmd and raise start; the word is taken at any rising
//   edge with start high and busy low. busy stays low, so a new word can be
//   taken every cycle.
//   Result channel: done pulses for one cycle with result valid in that same
//   cycle. There is no back pressure; the receiver must take it then.
//   Path: the word passes through the input register, then the evaluation logic
//   into the result register, which drives result.
//   Throughput: one word per cycle, bounded only by the single evaluation path.
//   Configuration: APB register use_watched at byte address 0 (reset 1). Writes
//   land at the access edge; pready is always high. Write it only while idle.
//   Reset: rst_n low clears the pipeline valid bits and sets use_watched to 1;
//   no result is lost or repeated across a stall since there are no stalls.
module clause_watch_evaluator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cwe_pkg::in_word_t             cmd,
    output logic                          done,
    output cwe_pkg::out_word_t            result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cwe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cwe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cwe_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import cwe_pkg::*;

    logic       use_watched_reg;
    logic       in_vld_reg;
    in_word_t   in_reg;
    logic       done_reg;
    out_word_t  result_reg;
    out_word_t  eval_word;
    logic       accept;
    logic       cfg_hit;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_USE_WATCHED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_watched_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && cfg_hit)
            use_watched_reg <= pwdata[0];
    end

    assign prdata = cfg_hit ? {{(APB_DATA_W-1){1'b0}}, use_watched_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
        end
    end

    // Payload registers: capture only when a word moves.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= cmd;
        if (in_vld_reg)
            result_reg <= eval_word;
    end

    cwe_eval u_eval (
        .cmd         (in_reg),
        .use_watched (use_watched_reg),
        .result      (eval_word)
    );

    assign done   = done_reg;
    assign result = result_reg;

`include "clause_watch_evaluator_unit_assert.svh"

    `CWE_ASSERT_NEXT(a_pipe_advance, in_vld_reg, done_reg)
    `CWE_ASSERT_NOW(a_all_false_excl, done_reg && result_reg.all_false, !result_reg.satisfied && !result_reg.any_unassigned)
    `CWE_ASSERT_NOW(a_lit_only_on_unit, done_reg && (result_reg.watch_event != EV_UNIT), result_reg.unit_literal == '0)
    `CWE_ASSERT_NOW(a_upos_zero_idle, done_reg && !result_reg.any_unassigned, result_reg.unit_position == '0)

endmodule

@@ dv/tb_clause_watch_evaluator_unit.sv @@
// Testbench for clause_watch_evaluator_unit: directed and random clause words,
// APB writes of use_watched between phases, and a scoreboard class that checks every result.
// Depends on cwe_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_clause_watch_evaluator_unit;
    import cwe_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 330;
    localparam int DRAIN_CYCLES = 8;

    class watch_result_board;
        bit        use_watched;
        out_word_t expected_results[$];
        int        errors;

        function new();
            use_watched = 1'b1;
            errors = 0;
        endfunction

        function void set_use_watched(bit value);
            use_watched = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Compute the result that one clause word must produce.
        function out_word_t evaluate_clause(in_word_t w);
            out_word_t        r;
            int               len;
            int               n_true;
            int               n_unk;
            int               k;
            int               other_lane;
            logic [VAL_W-1:0] v;
            logic             hit_a;
            logic             moved;
            r = '0;
            n_true = 0;
            n_unk = 0;
            len = (w.clause_length > EFF_LANES) ? EFF_LANES : int'(w.clause_length);
            r.new_watch_a = w.watch_a;
            r.new_watch_b = w.watch_b;
            r.watch_event = EV_NONE;
            for (k = 0; k < len; k++)
            begin
                v = w.literal_values[k*VAL_W +: VAL_W];
                if (v == VAL_TRUE)
                    n_true++;
                else if (v != VAL_FALSE)
                begin
                    if (n_unk == 0)
                        r.unit_position = LANE_W'(k);
                    n_unk++;
                end
            end
            r.satisfied      = (n_true > 0);
            r.all_false      = (n_true == 0) && (n_unk == 0);
            r.is_unit        = (n_true == 0) && (n_unk == 1);
            r.any_unassigned = (n_unk > 0);
            if (use_watched && len >= 2)
            begin
                if (w.kind == KIND_INIT)
                begin
                    if (w.literal_values[VAL_W-1:0] == VAL_FALSE)
                    begin
                        r.new_watch_a = 3'd1;
                        r.new_watch_b = 3'd0;
                    end
                    else
                    begin
                        r.new_watch_a = 3'd0;
                        r.new_watch_b = 3'd1;
                    end
                end
                else if (w.lit_a == w.falsed_literal || w.lit_b == w.falsed_literal)
                begin
                    hit_a = (w.lit_a == w.falsed_literal);
                    moved = 1'b0;
                    // Replacement: lowest non-false lane inside the length, skipping both watches.
                    for (k = 0; k < len && !moved; k++)
                    begin
                        if (k != w.watch_a && k != w.watch_b &&
                            w.literal_values[k*VAL_W +: VAL_W] != VAL_FALSE)
                        begin
                            if (hit_a)
                                r.new_watch_a = LANE_W'(k);
                            else
                                r.new_watch_b = LANE_W'(k);
                            moved = 1'b1;
                        end
                    end
                    if (moved)
                        r.watch_event = EV_MOVED;
                    else
                    begin
                        other_lane = hit_a ? int'(w.watch_b) : int'(w.watch_a);
                        v = w.literal_values[other_lane*VAL_W +: VAL_W];
                        if (v == VAL_FALSE)
                            r.watch_event = EV_CONFLICT;
                        else if (v == VAL_TRUE)
                            r.watch_event = EV_OTHER_TRUE;
                        else
                        begin
                            r.watch_event = EV_UNIT;
                            r.unit_literal = hit_a ? w.lit_b : w.lit_a;
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_clause(in_word_t w);
            expected_results = {expected_results, evaluate_clause(w)};
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_word;
            if (expected_results.size() == 0)
            begin
                $error("result word with no clause pending");
                errors++;
                return;
            end
            exp_word = expected_results.pop_front();
            compare_field("satisfied", exp_word.satisfied, got.satisfied);
            compare_field("all_false", exp_word.all_false, got.all_false);
            compare_field("is_unit", exp_word.is_unit, got.is_unit);
            compare_field("any_unassigned", exp_word.any_unassigned, got.any_unassigned);
            compare_field("unit_position", exp_word.unit_position, got.unit_position);
            compare_field("new_watch_a", exp_word.new_watch_a, got.new_watch_a);
            compare_field("new_watch_b", exp_word.new_watch_b, got.new_watch_b);
            compare_field("watch_event", int'(exp_word.watch_event), int'(got.watch_event));
            compare_field("unit_literal", exp_word.unit_literal, got.unit_literal);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    in_word_t                cmd_word;
    logic                    done;
    out_word_t               result_word;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    watch_result_board board;
    int                cycle_count;
    bit                idle_on;

    clause_watch_evaluator_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd_word),
        .done    (done),
        .result  (result_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check results before noting new words; the queue keeps them in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(result_word);
            if (start && !busy)
                board.note_clause(cmd_word);
        end
    end

    function automatic in_word_t clause_word(logic kind, logic [15:0] vals, int len,
                                             int wa, int wb, int la, int lb, int fl);
        in_word_t w;
        w.kind           = kind;
        w.literal_values = vals;
        w.clause_length  = LEN_W'(len);
        w.watch_a        = LANE_W'(wa);
        w.watch_b        = LANE_W'(wb);
        w.lit_a          = LIT_W'(la);
        w.lit_b          = LIT_W'(lb);
        w.falsed_literal = LIT_W'(fl);
        return w;
    endfunction

    function automatic in_word_t random_clause();
        in_word_t w;
        int       len;
        int       span;
        int       f_pct;
        int       k;
        int       pick;
        w.kind = ($urandom_range(99) < 20) ? KIND_INIT : KIND_UPDATE;
        len = ($urandom_range(99) < 10) ? $urandom_range(0, 15)
                                        : $urandom_range(2, EFF_LANES);
        w.clause_length = LEN_W'(len);
        span = (len > EFF_LANES) ? EFF_LANES : len;
        case ($urandom_range(4))
            0: f_pct = 30;
            1: f_pct = 70;
            2: f_pct = 90;
            default: f_pct = 100;
        endcase
        for (k = 0; k < LANE_CNT; k++)
            w.literal_values[k*VAL_W +: VAL_W] =
                ($urandom_range(99) < f_pct) ? VAL_FALSE : VAL_W'($urandom_range(1, 3));
        if ($urandom_range(99) < 8)
            w.literal_values = 16'($urandom);
        // Mostly distinct watches inside the clause; a few anywhere.
        if (span >= 2 && $urandom_range(99) < 85)
        begin
            w.watch_a = LANE_W'($urandom_range(0, span - 1));
            w.watch_b = LANE_W'($urandom_range(0, span - 2));
            if (w.watch_b >= w.watch_a)
                w.watch_b = w.watch_b + 1'b1;
        end
        else
        begin
            w.watch_a = LANE_W'($urandom_range(7));
            w.watch_b = LANE_W'($urandom_range(7));
        end
        // With every other lane false, let the watch lanes decide unit, conflict or true.
        if (f_pct == 100)
        begin
            w.literal_values[w.watch_a*VAL_W +: VAL_W] = VAL_W'($urandom_range(3));
            w.literal_values[w.watch_b*VAL_W +: VAL_W] = VAL_W'($urandom_range(3));
        end
        w.lit_a = LIT_W'($urandom);
        w.lit_b = LIT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
            w.falsed_literal = w.lit_a;
        else if (pick < 70)
            w.falsed_literal = w.lit_b;
        else if (pick < 76)
        begin
            w.lit_b = w.lit_a;
            w.falsed_literal = w.lit_a;
        end
        else
            w.falsed_literal = LIT_W'($urandom);
        return w;
    endfunction

    task automatic send_clause(in_word_t w);
        if (idle_on && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            cmd_word <= in_word_t'($urandom);
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        start <= 1'b1;
        cmd_word <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_use_watched(logic [APB_DATA_W-1:0] value);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_USE_WATCHED, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_use_watched(value[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(int count);
        int n;
        for (n = 0; n < count; n++)
            send_clause(random_clause());
    endtask

    initial
    begin
        board = new();
        cycle_count <= 0;
        idle_on  <= 1'b1;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        cmd_word <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with use_watched at its reset value.
        send_clause(clause_word(KIND_UPDATE, 16'h0000, 0, 0, 1, 5, 6, 5));
        send_clause(clause_word(KIND_UPDATE, 16'h0002, 1, 0, 1, 5, 6, 5));
        send_clause(clause_word(KIND_INIT, 16'h0018, 3, 2, 0, 1, 2, 1));
        send_clause(clause_word(KIND_INIT, 16'h0019, 4, 3, 2, 1, 2, 1));
        send_clause(clause_word(KIND_INIT, 16'h0000, 1, 4, 5, 1, 2, 1));
        send_clause(clause_word(KIND_UPDATE, 16'h0248, 5, 0, 1, 12, -7, 12));
        send_clause(clause_word(KIND_UPDATE, 16'h0002, 4, 2, 0, -3, 9, -3));
        send_clause(clause_word(KIND_UPDATE, 16'h0000, 4, 1, 3, 4, 8, 8));
        send_clause(clause_word(KIND_UPDATE, 16'h0010, 3, 0, 2, 7, 11, 7));
        send_clause(clause_word(KIND_UPDATE, 16'h0080, 4, 0, 1, 21, 21, 21));
        send_clause(clause_word(KIND_UPDATE, 16'h0AAA, 6, 0, 1, 1, 2, 3));
        send_clause(clause_word(KIND_UPDATE, 16'hFFFF, 8, 0, 1, 30, 31, 31));
        send_clause(clause_word(KIND_UPDATE, 16'h5555, 15, 0, 1, 30, 31, 30));
        send_clause(clause_word(KIND_INIT, 16'hAAAA, 12, 6, 7, 1, 2, 3));
        send_clause(clause_word(KIND_UPDATE, 16'h0800, 3, 5, 6, 40, 41, 41));
        send_clause(clause_word(KIND_UPDATE, 16'h0010, 4, 2, 2, 50, 50, 50));
        send_clause(clause_word(KIND_UPDATE, 16'h0020, 4, 2, 2, 50, 51, 51));
        send_clause(clause_word(KIND_UPDATE, 16'h0008, 2, 0, 1, -32768, 32767, -32768));
        send_clause(clause_word(KIND_UPDATE, 16'h0008, 2, 0, 1, 32767, -32767, 32767));
        send_clause(clause_word(KIND_UPDATE, 16'h0002, 2, 0, 1, 32767, -32767, -32767));
        send_clause(clause_word(KIND_INIT, 16'hFFFF, 8, 7, 7, -1, -1, -1));
        send_clause(clause_word(KIND_INIT, 16'h0000, 2, 3, 4, 9, 9, 9));
        send_clause(clause_word(KIND_UPDATE, 16'h0000, 8, 7, 6, -32767, 32767, 32767));

        run_random(PHASE_WORDS);
        write_use_watched(32'h0000_0000);
        run_random(PHASE_WORDS);
        write_use_watched(32'hFFFF_FFFF);
        // Back-to-back stretch: every cycle carries a word.
        idle_on <= 1'b0;
        run_random(PHASE_WORDS);
        idle_on <= 1'b1;
        write_use_watched(32'hFFFF_FFFE);
        run_random(PHASE_WORDS);
        write_use_watched(32'h0000_0001);
        run_random(PHASE_WORDS);
        start <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
